### hdl/mau_pkg.sv
// Package with shared types and constants of the modular arithmetic unit.
package mau_pkg;

	localparam int unsigned VW = 31;
	localparam int unsigned EW = 63;
	localparam logic [VW-1:0] RESET_MODULUS = 31'd1000000007;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INV = 3'd4,
		OP_POW = 3'd5
	} op_t;

	// Datapath commands.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,      // capture operands, start reduction of a
		CMD_RED_B,     // start reduction of b
		CMD_ADDSUB,    // add or subtract into result
		CMD_EU_INIT,   // load Euclid registers
		CMD_EU_DIV,    // start quotient division a / b
		CMD_EU_UPD,    // apply quotient
		CMD_EU_FIN,    // finish inverse
		CMD_MUL_RA,    // start mul res * base (or a * b)
		CMD_MUL_BB,    // start mul base * base
		CMD_POW_INIT,  // r = 1 % m
		CMD_ZERO       // result zero
	} cmd_e_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RED_A, ST_RED_B, ST_DISPATCH, ST_EU_DIV, ST_EU_WAIT,
		ST_EU_UPD, ST_EU_FIN, ST_MUL_WAIT, ST_POW_LOOP, ST_POW_SQ,
		ST_OUT
	} state_t;

	typedef struct packed {
		cmd_e_t cmd;
		logic   inv_into_b; // divide: result of inverse replaces b
		logic   mul_sel_a;  // multiply a*b rather than r*base
	} ctrl_t;

	typedef struct packed {
		logic unit_busy;
		logic eu_b_zero;
		logic exp_zero;
		logic exp_lsb;
		logic mod_small;
	} stat_t;

endpackage

### hdl/mau_if.sv
// Valid/ready channel interfaces for operations and results.
interface mau_op_if;
	logic valid;
	logic ready;
	logic [2:0] operation;
	logic [30:0] operand_a;
	logic [30:0] operand_b;
	logic [62:0] exponent;
	modport source (output valid, operation, operand_a, operand_b, exponent, input ready);
	modport sink (input valid, operation, operand_a, operand_b, exponent, output ready);
endinterface

interface mau_res_if;
	logic valid;
	logic ready;
	logic [30:0] result;
	logic no_inverse;
	modport source (output valid, result, no_inverse, input ready);
	modport sink (input valid, result, no_inverse, output ready);
endinterface

### hdl/mau_divider.sv
// Iterative restoring divider, one quotient bit a cycle, 64-bit dividend.
module mau_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [63:0] quotient,
	output logic [31:0] remainder
);
	logic [63:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [6:0]  cnt_q;
	logic [32:0] shifted;
	logic        take;

	// Trial subtract of the shifted partial remainder.
	always_comb begin
		shifted = {r_q[31:0], q_q[63]};
		take = shifted >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			r_q <= take ? shifted - {1'b0, d_q} : shifted;
			q_q <= {q_q[62:0], take};
		end
	end

	assign busy = (cnt_q != 7'd0);
	assign quotient = q_q;
	assign remainder = r_q[31:0];
endmodule

### hdl/mau_datapath.sv
// Datapath: operand and Euclid registers, two multipliers and a shared divider.
module mau_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  mau_pkg::ctrl_t    ctrl,
	output mau_pkg::stat_t    stat,
	input  logic [30:0]       modulus,
	input  logic [2:0]        operation,
	input  logic [30:0]       operand_a,
	input  logic [30:0]       operand_b,
	input  logic [62:0]       exponent,
	output logic [30:0]       result,
	output logic              no_inverse
);
	import mau_pkg::*;

	logic [30:0] a_q, b_q, r_q, m_q;
	logic [62:0] e_q;
	logic        bad_q;
	logic        sub_q;
	// Euclid registers: remainders and signed coefficients.
	logic [31:0]        ea_q, eb_q;
	logic signed [32:0] eu_q, ev_q;
	logic [1:0]         dsel_q; // divider result target
	localparam logic [1:0] D_A = 2'd0, D_B = 2'd1, D_MUL = 2'd2, D_EU = 2'd3;
	logic [1:0]  mtgt_q; // 0 r, 1 base
	logic        dv_busy_q;

	logic        dv_start, dv_busy;
	logic [63:0] dv_num, dv_quo;
	logic [31:0] dv_den, dv_rem;
	logic [61:0] prod_s1;
	logic [30:0] mx, my;
	logic [31:0] sum;
	logic signed [65:0] tv;
	logic [31:0] tq;
	logic signed [32:0] u_fix;
	logic        mul_pend_q;
	logic        red_start;
	logic [63:0] red_num;
	logic        dv_go;
	logic [63:0] dv_n2;

	mau_divider u_div (
		.clk, .arst_n, .start(dv_go), .dividend(dv_n2), .divisor(dv_den),
		.busy(dv_busy), .quotient(dv_quo), .remainder(dv_rem)
	);

	// Multiplier operand choice.
	always_comb begin
		mx = ctrl.mul_sel_a ? a_q : r_q;
		my = ctrl.mul_sel_a ? b_q : a_q;
		if (ctrl.cmd == CMD_MUL_BB) my = a_q;
		if (ctrl.cmd == CMD_MUL_BB) mx = a_q;
	end

	// Divider start and operand selection.
	always_comb begin
		dv_start = 1'b0;
		dv_num = '0;
		dv_den = {1'b0, m_q};
		case (ctrl.cmd)
			CMD_LOAD: begin
				dv_start = 1'b1;
				dv_num = {33'd0, operand_a};
				dv_den = {1'b0, modulus};
			end
			CMD_RED_B: begin
				dv_start = 1'b1;
				dv_num = {33'd0, b_q};
			end
			CMD_EU_DIV: begin
				dv_start = 1'b1;
				dv_num = {32'd0, ea_q};
				dv_den = eb_q;
			end
			default: begin
			end
		endcase
	end

	assign sum = sub_q ? {1'b0, a_q} + {1'b0, m_q} - {1'b0, b_q} : {1'b0, a_q} + {1'b0, b_q};
	assign tq = dv_quo[31:0];
	assign tv = 66'(ev_q) * 66'($signed({1'b0, tq}));
	assign u_fix = (eu_q < 0) ? eu_q + $signed({2'b00, m_q}) : eu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
		end else begin
			dv_busy_q <= dv_go || dv_busy;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mx * my;
		case (ctrl.cmd)
			CMD_LOAD: begin
				m_q <= modulus;
				b_q <= operand_b;
				e_q <= exponent;
				sub_q <= (operation == OP_SUB);
				bad_q <= 1'b0;
				dsel_q <= D_A;
			end
			CMD_RED_B: dsel_q <= D_B;
			CMD_ADDSUB: r_q <= (sum >= {1'b0, m_q}) ? 31'(sum - {1'b0, m_q}) : sum[30:0];
			CMD_EU_INIT: begin
				ea_q <= ctrl.inv_into_b ? {1'b0, b_q} : {1'b0, a_q};
				eb_q <= {1'b0, m_q};
				eu_q <= 33'sd1;
				ev_q <= 33'sd0;
			end
			CMD_EU_DIV: dsel_q <= D_EU;
			CMD_EU_UPD: begin
				ea_q <= eb_q;
				eb_q <= dv_rem;
				eu_q <= ev_q;
				ev_q <= eu_q - 33'(tv);
			end
			CMD_EU_FIN: begin
				bad_q <= (ea_q != 32'd1);
				if (ctrl.inv_into_b) b_q <= u_fix[30:0];
				else r_q <= u_fix[30:0];
			end
			CMD_MUL_RA: begin
				dsel_q <= D_MUL;
				mtgt_q <= 2'd0;
			end
			CMD_MUL_BB: begin
				dsel_q <= D_MUL;
				mtgt_q <= 2'd1;
				e_q <= e_q >> 1;
			end
			CMD_POW_INIT: r_q <= 31'd1;
			CMD_ZERO: begin
				r_q <= '0;
				bad_q <= 1'b0;
			end
			default: begin
			end
		endcase
		// Divider completion writes its remainder to the selected target.
		if (dv_busy_q && !dv_busy && !dv_go) begin
			case (dsel_q)
				D_A: a_q <= dv_rem[30:0];
				D_B: b_q <= dv_rem[30:0];
				D_MUL: begin
					if (mtgt_q == 2'd0) r_q <= dv_rem[30:0];
					else a_q <= dv_rem[30:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Product reduction runs on the shared divider, started in the cycle after the multiply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_pend_q <= 1'b0;
		end else begin
			mul_pend_q <= (ctrl.cmd == CMD_MUL_RA) || (ctrl.cmd == CMD_MUL_BB);
		end
	end

	assign red_start = mul_pend_q;
	assign red_num = {2'b00, prod_s1};

	// The shared divider sees either a direct start or a product reduction.
	assign dv_go = dv_start || red_start;
	assign dv_n2 = red_start ? red_num : dv_num;

	assign stat.unit_busy = dv_busy || dv_busy_q || mul_pend_q || dv_start;
	assign stat.eu_b_zero = (eb_q == 32'd0);
	assign stat.exp_zero = (e_q == '0);
	assign stat.exp_lsb = e_q[0];
	assign stat.mod_small = (modulus < 31'd2);
	assign result = r_q;
	assign no_inverse = bad_q;
endmodule

### hdl/mau_controller.sv
// Controller state machine sequencing the datapath through each operation.
module mau_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [2:0]     operation,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  mau_pkg::stat_t stat,
	output mau_pkg::ctrl_t ctrl
);
	import mau_pkg::*;

	state_t state_q, state_n;
	logic [2:0] op_q;
	logic inv_done_q; // divide: inverse of b is done
	state_t ret_q;    // state after a multiply completes
	state_t ret_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= '0;
			inv_done_q <= 1'b0;
			ret_q <= ST_OUT;
		end else begin
			state_q <= state_n;
			ret_q <= ret_n;
			if (state_q == ST_IDLE && in_valid) begin
				op_q <= operation;
				inv_done_q <= 1'b0;
			end
			if (ctrl.cmd == CMD_EU_FIN) inv_done_q <= 1'b1;
		end
	end

	// Next-state logic.
	always_comb begin
		state_n = state_q;
		ret_n = ret_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_RED_A;
			ST_RED_A: if (!stat.unit_busy) state_n = stat.mod_small ? ST_OUT : ST_RED_B;
			ST_RED_B: state_n = ST_DISPATCH;
			ST_DISPATCH: begin
				if (!stat.unit_busy) begin
					case (op_q)
						OP_ADD, OP_SUB: state_n = ST_OUT;
						OP_MUL: begin
							state_n = ST_MUL_WAIT;
							ret_n = ST_OUT;
						end
						OP_DIV: begin
							if (inv_done_q) begin
								state_n = ST_MUL_WAIT;
								ret_n = ST_OUT;
							end else begin
								state_n = ST_EU_DIV;
							end
						end
						OP_INV: state_n = ST_EU_DIV;
						OP_POW: state_n = ST_POW_LOOP;
						default: state_n = ST_OUT;
					endcase
				end
			end
			ST_EU_DIV: state_n = stat.eu_b_zero ? ST_EU_FIN : ST_EU_WAIT;
			ST_EU_WAIT: if (!stat.unit_busy) state_n = ST_EU_UPD;
			ST_EU_UPD: state_n = ST_EU_DIV;
			ST_EU_FIN: state_n = (op_q == OP_DIV) ? ST_DISPATCH : ST_OUT;
			ST_MUL_WAIT: if (!stat.unit_busy) state_n = ret_q;
			ST_POW_LOOP: begin
				if (stat.exp_zero) begin
					state_n = ST_OUT;
				end else if (stat.exp_lsb) begin
					state_n = ST_MUL_WAIT;
					ret_n = ST_POW_SQ;
				end else begin
					state_n = ST_POW_SQ;
				end
			end
			ST_POW_SQ: begin
				state_n = ST_MUL_WAIT;
				ret_n = ST_POW_LOOP;
			end
			ST_OUT: if (out_ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// Command output logic.
	always_comb begin
		ctrl.cmd = CMD_NONE;
		ctrl.inv_into_b = (op_q == OP_DIV);
		ctrl.mul_sel_a = (op_q == OP_MUL) || (op_q == OP_DIV);
		case (state_q)
			ST_IDLE: if (in_valid) ctrl.cmd = CMD_LOAD;
			ST_RED_A: if (!stat.unit_busy && stat.mod_small) ctrl.cmd = CMD_ZERO;
			ST_RED_B: ctrl.cmd = CMD_RED_B;
			ST_DISPATCH: begin
				if (!stat.unit_busy) begin
					case (op_q)
						OP_ADD, OP_SUB: ctrl.cmd = CMD_ADDSUB;
						OP_MUL: ctrl.cmd = CMD_MUL_RA;
						OP_DIV: ctrl.cmd = inv_done_q ? CMD_MUL_RA : CMD_EU_INIT;
						OP_INV: ctrl.cmd = CMD_EU_INIT;
						OP_POW: ctrl.cmd = CMD_POW_INIT;
						default: ctrl.cmd = CMD_ZERO;
					endcase
				end
			end
			ST_EU_DIV: ctrl.cmd = stat.eu_b_zero ? CMD_NONE : CMD_EU_DIV;
			ST_EU_UPD: ctrl.cmd = CMD_EU_UPD;
			ST_EU_FIN: ctrl.cmd = CMD_EU_FIN;
			ST_POW_LOOP: begin
				if (!stat.exp_zero && stat.exp_lsb) begin
					ctrl.cmd = CMD_MUL_RA;
				end
			end
			ST_POW_SQ: ctrl.cmd = CMD_MUL_BB;
			default: ctrl.cmd = CMD_NONE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
endmodule

### hdl/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit.
// Usage: operations arrive on the op channel (operation, operand_a, operand_b,
// exponent) and one result per transaction leaves on the res channel
// (result, no_inverse). The modulus register is written through cfg_we and
// cfg_wdata; the user must do so only while the block is idle, since the
// block itself does not enforce it. Reset loads 1000000007. One transaction
// is worked at a time. Every reduction and every Euclid quotient runs on
// one shared 64-step restoring divider. Inverse uses the divider once per
// Euclid step, divide adds one multiply to that, and power does one
// multiply per squaring and per set exponent bit, for exponents up to 63
// bits wide. The result is held with valid high until the receiver takes
// it; a stalled receiver stalls the block, and no new transaction is
// accepted meanwhile. Reset returns the controller to idle with no result
// pending.
module modular_arithmetic_unit (
	input  logic   clk,
	input  logic   arst_n,
	mau_op_if.sink   op,
	mau_res_if.source res,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);
	import mau_pkg::*;

	logic [30:0] modulus_q;
	ctrl_t ctrl;
	stat_t stat;

	// Modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= RESET_MODULUS;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	mau_controller u_ctrl (
		.clk, .arst_n,
		.in_valid(op.valid), .operation(op.operation), .in_ready(op.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.stat, .ctrl
	);

	mau_datapath u_dp (
		.clk, .arst_n, .ctrl, .stat,
		.modulus(modulus_q), .operation(op.operation), .operand_a(op.operand_a),
		.operand_b(op.operand_b), .exponent(op.exponent),
		.result(res.result), .no_inverse(res.no_inverse)
	);

`ifndef ASSERT_OFF
	// No new transaction while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !op.ready) else $error("accept while result pending");
	// A result stays until taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid) else $error("result dropped");
	// Result below the modulus when presented, for a modulus above one.
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && modulus_q > 31'd1 |-> res.result < modulus_q)
		else $error("result out of range");
`endif
endmodule

### test/tb_modular_arithmetic_unit.sv
// Self-checking testbench for the modular arithmetic unit.
`timescale 1ns / 100ps

module tb_modular_arithmetic_unit;
	import mau_pkg::*;

	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam int unsigned STALL_LIMIT = 60000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned ITEMS_PER_PHASE = 190;
	localparam int unsigned NUM_PHASES = 8;

	typedef struct {
		logic [30:0] result;
		logic        no_inverse;
	} answer_t;

	typedef struct {
		logic [2:0]  op;
		logic [30:0] a;
		logic [30:0] b;
		logic [62:0] e;
		bit          typed;
		logic [30:0] result;
		logic        no_inverse;
	} vector_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [30:0] cfg_wdata;

	mau_op_if  op_if ();
	mau_res_if res_if ();

	modular_arithmetic_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_if.sink),
		.res      (res_if.source),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	answer_t answers_due[$];
	logic [30:0] cur_modulus;
	bit quiet;
	int unsigned errors;
	int unsigned idle_cycles;
	int unsigned stall_left;

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Extended Euclid: coefficient u with x*u congruent to gcd, and a flag when gcd is not one.
	function automatic longint unsigned euclid_inverse(input longint unsigned x,
			input longint unsigned m, output bit no_inv);
		longint a, b, u, v, q, na, nu;
		a = longint'(x);
		b = longint'(m);
		u = 1;
		v = 0;
		while (b != 0) begin
			q = a / b;
			na = a - q * b;
			nu = u - q * v;
			a = b;
			b = na;
			u = v;
			v = nu;
		end
		no_inv = (a != 1);
		if (u < 0)
			u = u + longint'(m);
		if (u < 0 || longint'(u) >= longint'(m))
			u = 0;
		return longint'(u);
	endfunction

	// Expected answer of one operation under the given modulus.
	function automatic answer_t modular_answer(input logic [2:0] op, input logic [30:0] opa,
			input logic [30:0] opb, input logic [62:0] e, input logic [30:0] modulus);
		longint unsigned m, a, b, r, base, inv;
		logic [62:0] k;
		bit bad;
		answer_t ans;
		m = modulus;
		r = 0;
		bad = 1'b0;
		if (m >= 2) begin
			a = opa % m;
			b = opb % m;
			case (op)
				OP_ADD: begin
					r = a + b;
					if (r >= m) r = r - m;
				end
				OP_SUB: begin
					r = a + (m - b);
					if (r >= m) r = r - m;
				end
				OP_MUL: r = (a * b) % m;
				OP_DIV: begin
					inv = euclid_inverse(b, m, bad);
					r = (a * inv) % m;
				end
				OP_INV: r = euclid_inverse(a, m, bad);
				OP_POW: begin
					r = 1 % m;
					base = a;
					k = e;
					while (k != 0) begin
						if (k[0])
							r = (r * base) % m;
						base = (base * base) % m;
						k = k >> 1;
					end
				end
				default: r = 0;
			endcase
		end
		ans.result = r[30:0];
		ans.no_inverse = bad;
		return ans;
	endfunction

	// Offers one operation, at times after a random idle gap, waits for its transaction, then records the expectation.
	task automatic send_operation(input vector_t vec);
		int unsigned gap;
		answer_t ans;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			op_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_if.valid <= 1'b1;
		op_if.operation <= vec.op;
		op_if.operand_a <= vec.a;
		op_if.operand_b <= vec.b;
		op_if.exponent <= vec.e;
		do @(posedge clk); while (!op_if.ready);
		if (vec.typed) begin
			ans.result = vec.result;
			ans.no_inverse = vec.no_inverse;
		end else begin
			ans = modular_answer(vec.op, vec.a, vec.b, vec.e, cur_modulus);
		end
		answers_due.push_back(ans);
	endtask

	// Waits for the block to drain, then loads a new modulus.
	task automatic load_modulus(input logic [30:0] value);
		op_if.valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_modulus = value;
	endtask

	// Operand picker that favors small values and values around the modulus.
	function automatic logic [30:0] pick_operand();
		longint unsigned v;
		case ($urandom_range(0, 3))
			0: v = 64'($urandom_range(0, 20));
			1: v = longint'(cur_modulus) * 64'($urandom_range(0, 2)) +
				64'($urandom_range(0, 2));
			default: v = 64'($urandom_range(0, 2147483646));
		endcase
		if (v > 2147483646)
			v = 2147483646;
		return v[30:0];
	endfunction

	function automatic vector_t random_operation();
		vector_t vec;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 4) vec.op = OP_ADD;
		else if (pick < 8) vec.op = OP_SUB;
		else if (pick < 12) vec.op = OP_MUL;
		else if (pick < 14) vec.op = OP_DIV;
		else if (pick < 16) vec.op = OP_INV;
		else if (pick < 19) vec.op = OP_POW;
		else vec.op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
		vec.a = pick_operand();
		vec.b = pick_operand();
		// Long exponents are slow, so only a few use the full width.
		if ($urandom_range(0, 29) == 0)
			vec.e = 63'({$urandom, $urandom});
		else
			vec.e = 63'($urandom_range(0, 4095));
		vec.typed = 1'b0;
		return vec;
	endfunction

	// Result side: checks each transaction, stalls at random and watches for a hang.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result %0d no_inverse %0b", $time,
						res_if.result, res_if.no_inverse);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (res_if.result !== want.result) begin
						$display("%0t: result expected %0d actual %0d", $time,
							want.result, res_if.result);
						errors++;
					end
					if (res_if.no_inverse !== want.no_inverse) begin
						$display("%0t: no_inverse expected %0b actual %0b", $time,
							want.no_inverse, res_if.no_inverse);
						errors++;
					end
				end
			end
			if ((res_if.valid && res_if.ready) || (op_if.valid && op_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 13);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Stimulus: directed table under the reset modulus, then random phases.
	initial begin
		vector_t directed[$];
		logic [30:0] moduli [NUM_PHASES];
		vector_t vec;
		errors = 0;
		idle_cycles = 0;
		stall_left = 0;
		quiet = 1'b0;
		cur_modulus = RESET_MODULUS;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		op_if.valid = 1'b0;
		op_if.operation = OP_ADD;
		op_if.operand_a = '0;
		op_if.operand_b = '0;
		op_if.exponent = '0;
		res_if.ready = 1'b0;

		directed = '{
			'{OP_ADD, 31'd0, 31'd0, 63'd0, 1'b1, 31'd0, 1'b0},
			'{OP_ADD, 31'd2147483646, 31'd2147483646, 63'd0, 1'b0, 31'd0, 1'b0},
			'{OP_SUB, 31'd0, 31'd1, 63'd0, 1'b1, 31'd1000000006, 1'b0},
			'{OP_SUB, 31'd3, 31'd2147483646, 63'd0, 1'b0, 31'd0, 1'b0},
			'{OP_MUL, 31'd2147483646, 31'd2147483646, 63'd0, 1'b0, 31'd0, 1'b0},
			'{OP_MUL, 31'd1000000006, 31'd1000000006, 63'd0, 1'b1, 31'd1, 1'b0},
			'{OP_DIV, 31'd6, 31'd3, 63'd0, 1'b1, 31'd2, 1'b0},
			'{OP_DIV, 31'd5, 31'd0, 63'd0, 1'b1, 31'd0, 1'b1},
			'{OP_DIV, 31'd2147483646, 31'd1000000007, 63'd0, 1'b1, 31'd0, 1'b1},
			'{OP_INV, 31'd0, 31'd0, 63'd0, 1'b1, 31'd0, 1'b1},
			'{OP_INV, 31'd1, 31'd0, 63'd0, 1'b1, 31'd1, 1'b0},
			'{OP_INV, 31'd1000000007, 31'd0, 63'd0, 1'b1, 31'd0, 1'b1},
			'{OP_INV, 31'd2147483646, 31'd0, 63'd0, 1'b0, 31'd0, 1'b0},
			'{OP_POW, 31'd2, 31'd0, 63'd0, 1'b1, 31'd1, 1'b0},
			'{OP_POW, 31'd0, 31'd0, 63'd0, 1'b1, 31'd1, 1'b0},
			'{OP_POW, 31'd2, 31'd0, 63'd10, 1'b1, 31'd1024, 1'b0},
			'{OP_POW, 31'd2147483646, 31'd0, 63'h7FFFFFFFFFFFFFFF, 1'b0, 31'd0, 1'b0},
			'{OP_POW, 31'd0, 31'd0, 63'd5, 1'b1, 31'd0, 1'b0},
			'{OP_RSVD6, 31'd7, 31'd9, 63'd3, 1'b1, 31'd0, 1'b0},
			'{OP_RSVD7, 31'd2147483646, 31'd2147483646, 63'h7FFFFFFFFFFFFFFF, 1'b1,
				31'd0, 1'b0}
		};
		// Extremes, a prime, composites with shared factors and random moduli.
		moduli[0] = 31'd2;
		moduli[1] = 31'd2147483647;
		moduli[2] = 31'd65536;
		moduli[3] = 31'd13;
		moduli[4] = 31'($urandom_range(2, 2147483647));
		moduli[5] = 31'd360360;
		moduli[6] = 31'($urandom_range(2, 1000));
		moduli[7] = RESET_MODULUS;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_operation(directed[i]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			load_modulus(moduli[p]);
			// The final phase runs without idling on either side.
			if (p == NUM_PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				vec = random_operation();
				send_operation(vec);
			end
		end
		op_if.valid <= 1'b0;

		while (answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
hdl/mau_pkg.sv
hdl/mau_if.sv
hdl/mau_divider.sv
hdl/mau_datapath.sv
hdl/mau_controller.sv
hdl/modular_arithmetic_unit.sv
test/tb_modular_arithmetic_unit.sv
